// File: hdl/lper_pkg.sv
// ----------------------------------------------------------------------------
// lper_pkg
// shared types and constants of the length-prefixed event ring
// ----------------------------------------------------------------------------
package lper_pkg;

	localparam int unsigned BUF_WORDS_DEF = 4096;
	localparam int unsigned WORD_W        = 32;
	localparam int unsigned LEN_W         = 12;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} lper_cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_REFUSED = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_BAD_LEN = 2'd3
	} lper_status_t;

	typedef enum logic [1:0] {
		FSM_IDLE     = 2'd0,
		FSM_PUSH_LEN = 2'd1,
		FSM_POP_WAIT = 2'd2
	} lper_state_t;

	typedef struct packed {
		lper_cmd_t          command;
		logic [WORD_W-1:0]  data_word;
		logic [LEN_W-1:0]   event_words;
		logic [WORD_W-1:0]  serial;
	} lper_req_t;

	typedef struct packed {
		lper_status_t       status;
		logic [WORD_W-1:0]  out_word;
		logic               last_word;
		logic [WORD_W-1:0]  event_count;
	} lper_rsp_t;

endpackage

// File: hdl/lper_ring_mem.sv
// ----------------------------------------------------------------------------
// lper_ring_mem
// word ring storage: one write port, two registered read ports
// ----------------------------------------------------------------------------
module lper_ring_mem #(
	parameter int unsigned DEPTH = lper_pkg::BUF_WORDS_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [lper_pkg::WORD_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr_a,
	input  logic [AW-1:0]              rd_addr_b,
	output logic [lper_pkg::WORD_W-1:0] rd_data_a,
	output logic [lper_pkg::WORD_W-1:0] rd_data_b
);
	import lper_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// File: hdl/lper_ctrl.sv
// ----------------------------------------------------------------------------
// lper_ctrl
// command sequencer: admission checks, ring pointers, counters, memory access
// ----------------------------------------------------------------------------
module lper_ctrl #(
	parameter int unsigned BUF_WORDS = lper_pkg::BUF_WORDS_DEF,
	parameter int unsigned AW        = $clog2(BUF_WORDS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  lper_pkg::lper_req_t         req,
	input  logic                        q_full,
	output logic                        res_valid,
	output lper_pkg::lper_rsp_t         res,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [lper_pkg::WORD_W-1:0] wr_data,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr_a,
	output logic [AW-1:0]               rd_addr_b,
	input  logic [lper_pkg::WORD_W-1:0] rd_data_a,
	input  logic [lper_pkg::WORD_W-1:0] rd_data_b
);
	import lper_pkg::*;

	localparam int unsigned SW = ((AW > LEN_W) ? AW : LEN_W) + 2;
	localparam logic [63:0] WRAP_REM = (64'd1 << 32) % 64'(BUF_WORDS);
	localparam logic [SW-1:0] BUF_SW = SW'(BUF_WORDS);
	localparam logic [SW-1:0] WRAP_ADJ = SW'(64'(BUF_WORDS) - WRAP_REM);

	lper_state_t state_q, state_d;

	logic [WORD_W-1:0] win_q, win_d, wout_q, wout_d;
	logic [WORD_W-1:0] evin_q, evin_d, evout_q, evout_d;
	logic [AW-1:0]     in_idx_q, in_idx_d, out_idx_q, out_idx_d;
	logic [LEN_W-1:0]  push_rem_q, push_rem_d, push_off_q, push_off_d;
	logic [LEN_W-1:0]  pop_rem_q, pop_rem_d, pop_off_q, pop_off_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [AW-1:0]     len_addr_q, len_addr_d;

	logic              accept;
	logic [LEN_W:0]    n1;
	logic [WORD_W-1:0] used;
	logic              bad_len, ser_ok, fits;
	logic [LEN_W-1:0]  off_new, rem_new, pn;
	logic [LEN_W:0]    k;
	logic [WORD_W:0]   sum;

	function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
	                                            input logic [LEN_W-1:0] off);
		logic [SW-1:0] t;
		t = SW'(base) + SW'(off);
		if (t >= BUF_SW) t = t - BUF_SW;
		return t[AW-1:0];
	endfunction

	// advance a ring index by k words, correcting for the 32-bit counter wrap
	function automatic logic [AW-1:0] adv_idx(input logic [AW-1:0] idx,
	                                           input logic [LEN_W:0] step,
	                                           input logic carry);
		logic [SW-1:0] t;
		t = SW'(idx) + SW'(step) + (carry ? WRAP_ADJ : '0);
		if (t >= BUF_SW) t = t - BUF_SW;
		if (t >= BUF_SW) t = t - BUF_SW;
		return t[AW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FSM_IDLE;
			win_q      <= '0;
			wout_q     <= '0;
			evin_q     <= '0;
			evout_q    <= '0;
			in_idx_q   <= '0;
			out_idx_q  <= '0;
			push_rem_q <= '0;
			push_off_q <= '0;
			pop_rem_q  <= '0;
			pop_off_q  <= '0;
		end else begin
			state_q    <= state_d;
			win_q      <= win_d;
			wout_q     <= wout_d;
			evin_q     <= evin_d;
			evout_q    <= evout_d;
			in_idx_q   <= in_idx_d;
			out_idx_q  <= out_idx_d;
			push_rem_q <= push_rem_d;
			push_off_q <= push_off_d;
			pop_rem_q  <= pop_rem_d;
			pop_off_q  <= pop_off_d;
		end
	end

	always_ff @(posedge clk) begin
		len_q      <= len_d;
		len_addr_q <= len_addr_d;
	end

	assign n1      = {1'b0, req.event_words} + (LEN_W+1)'(1);
	assign used    = win_q - wout_q;
	assign bad_len = (req.event_words == '0) || (32'(n1) >= 32'(BUF_WORDS));
	assign ser_ok  = (req.serial == '0) || ((req.serial - 32'd1) == evin_q);
	assign fits    = used < (32'(BUF_WORDS) - 32'(n1));

	assign req_stall = (state_q != FSM_IDLE) || q_full;
	assign accept    = req_valid && !req_stall;
	assign rd_addr_a = out_idx_q;
	assign rd_addr_b = ring_pos(out_idx_q, pop_off_q + LEN_W'(1));

	always_comb begin
		state_d    = state_q;
		win_d      = win_q;
		wout_d     = wout_q;
		evin_d     = evin_q;
		evout_d    = evout_q;
		in_idx_d   = in_idx_q;
		out_idx_d  = out_idx_q;
		push_rem_d = push_rem_q;
		push_off_d = push_off_q;
		pop_rem_d  = pop_rem_q;
		pop_off_d  = pop_off_q;
		len_d      = len_q;
		len_addr_d = len_addr_q;
		res_valid  = 1'b0;
		res        = '0;
		wr_en      = 1'b0;
		wr_addr    = in_idx_q;
		wr_data    = req.data_word;
		rd_en      = 1'b0;
		off_new    = '0;
		rem_new    = '0;
		pn         = '0;
		k          = '0;
		sum        = '0;

		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					res_valid = 1'b1;
					case (req.command)
						CMD_PUSH: begin
							res.event_count = evin_q;
							if (push_rem_q == '0 && bad_len) begin
								res.status = ST_BAD_LEN;
							end else if (push_rem_q == '0 && (!ser_ok || !fits)) begin
								res.status = ST_REFUSED;
							end else begin
								wr_en = 1'b1;
								if (push_rem_q == '0) begin
									// length word goes in on the following cycle
									wr_addr    = ring_pos(in_idx_q, LEN_W'(1));
									len_d      = req.event_words;
									len_addr_d = in_idx_q;
									state_d    = FSM_PUSH_LEN;
									off_new    = LEN_W'(1);
									rem_new    = req.event_words - LEN_W'(1);
								end else begin
									off_new = push_off_q + LEN_W'(1);
									wr_addr = ring_pos(in_idx_q, off_new);
									rem_new = push_rem_q - LEN_W'(1);
								end
								push_off_d = off_new;
								push_rem_d = rem_new;
								if (rem_new == '0) begin
									k               = {1'b0, off_new} + (LEN_W+1)'(1);
									sum             = {1'b0, win_q} + (WORD_W+1)'(k);
									win_d           = sum[WORD_W-1:0];
									in_idx_d        = adv_idx(in_idx_q, k, sum[WORD_W]);
									evin_d          = evin_q + 32'd1;
									push_off_d      = '0;
									res.last_word   = 1'b1;
									res.event_count = evin_q + 32'd1;
								end
							end
						end
						CMD_POP: begin
							if (pop_rem_q == '0 && win_q == wout_q) begin
								res.status      = ST_EMPTY;
								res.event_count = evout_q;
							end else begin
								res_valid = 1'b0;
								rd_en     = 1'b1;
								state_d   = FSM_POP_WAIT;
							end
						end
						CMD_CLEAR: begin
							win_d      = '0;
							wout_d     = '0;
							evin_d     = '0;
							evout_d    = '0;
							in_idx_d   = '0;
							out_idx_d  = '0;
							push_rem_d = '0;
							push_off_d = '0;
							pop_rem_d  = '0;
							pop_off_d  = '0;
						end
						default: begin
						end
					endcase
				end
			end
			FSM_PUSH_LEN: begin
				wr_en   = 1'b1;
				wr_addr = len_addr_q;
				wr_data = WORD_W'(len_q);
				state_d = FSM_IDLE;
			end
			FSM_POP_WAIT: begin
				res_valid    = 1'b1;
				res.out_word = rd_data_b;
				if (pop_rem_q == '0) begin
					pn      = (rd_data_a[LEN_W-1:0] == '0) ? LEN_W'(1) : rd_data_a[LEN_W-1:0];
					off_new = LEN_W'(1);
					rem_new = pn - LEN_W'(1);
				end else begin
					off_new = pop_off_q + LEN_W'(1);
					rem_new = pop_rem_q - LEN_W'(1);
				end
				pop_off_d       = off_new;
				pop_rem_d       = rem_new;
				res.event_count = evout_q;
				if (rem_new == '0) begin
					k               = {1'b0, off_new} + (LEN_W+1)'(1);
					sum             = {1'b0, wout_q} + (WORD_W+1)'(k);
					wout_d          = sum[WORD_W-1:0];
					out_idx_d       = adv_idx(out_idx_q, k, sum[WORD_W]);
					evout_d         = evout_q + 32'd1;
					pop_off_d       = '0;
					res.last_word   = 1'b1;
					res.event_count = evout_q + 32'd1;
				end
				state_d = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/lper_out_q.sv
// ----------------------------------------------------------------------------
// lper_out_q
// two-entry result queue between the sequencer and the response channel
// ----------------------------------------------------------------------------
module lper_out_q (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lper_pkg::lper_rsp_t din,
	output logic                full,
	output logic                valid,
	input  logic                stall,
	output lper_pkg::lper_rsp_t dout
);
	import lper_pkg::*;

	lper_rsp_t  ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign valid = (cnt_q != 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign pop   = valid && !stall;
	assign dout  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= din;
		end
	end

endmodule

// File: hdl/length_prefixed_event_ring.sv
// ----------------------------------------------------------------------------
// length_prefixed_event_ring
// ring of 32-bit words holding variable-length events, each stored as a
// length word followed by its payload words
// ----------------------------------------------------------------------------
// req channel carries one command per transfer: push a word, pop a word,
// clear, or no-op. every request yields exactly one response on rsp.
// a push of an event's first word is refused (status 1) when out of order
// or when the event does not fit, and the producer retries later. the event
// becomes visible to pop on its last word.
// command sequencing:
//   push, later word: written on acceptance; the next word is taken when req_stall is low
//   push, first word: the length word takes a second write slot (PUSH_LEN)
//   pop: the ring memory read is registered and the word is answered from
//   POP_WAIT; no new request is taken until the popped word is answered
//   clear, no-op, refused push, empty pop: answered on acceptance
// a two-entry response queue keeps accepting requests while one response
// waits; req_stall rises when the queue is full or a length write or pop
// read is in progress. arst_n empties the ring, zeroes all counters and
// closes open events; ring contents are not cleared and need not be.
// ----------------------------------------------------------------------------
module length_prefixed_event_ring #(
	parameter int unsigned BUF_WORDS = lper_pkg::BUF_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  lper_pkg::lper_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output lper_pkg::lper_rsp_t rsp
);
	import lper_pkg::*;

	localparam int unsigned AW = $clog2(BUF_WORDS);

	logic              q_full;
	logic              res_valid;
	lper_rsp_t         res;
	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr_a, rd_addr_b;
	logic [WORD_W-1:0] wr_data, rd_data_a, rd_data_b;

	lper_ctrl #(
		.BUF_WORDS (BUF_WORDS),
		.AW        (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_full    (q_full),
		.res_valid (res_valid),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	lper_ring_mem #(
		.DEPTH (BUF_WORDS),
		.AW    (AW)
	) u_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	lper_out_q u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.din    (res),
		.full   (q_full),
		.valid  (rsp_valid),
		.stall  (rsp_stall),
		.dout   (rsp)
	);

endmodule

// File: hdl/lper_checker.sv
// ----------------------------------------------------------------------------
// lper_checker
// port-level checks of the event ring, bound to the top level
// ----------------------------------------------------------------------------
module lper_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input lper_pkg::lper_req_t req,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input lper_pkg::lper_rsp_t rsp
);
	import lper_pkg::*;

	// a stalled response stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// only a successful transfer carries data or an end mark
	a_fail_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.out_word == '0 && !rsp.last_word)
		else $error("failed command carried a word or end mark");

	// clear into an idle response channel answers next cycle with all zero
	a_clear_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.command == CMD_CLEAR && !rsp_valid
		|=> rsp_valid && rsp.status == ST_OK && rsp.event_count == '0
		    && rsp.out_word == '0 && !rsp.last_word)
		else $error("clear response wrong");

endmodule

bind length_prefixed_event_ring lper_checker u_lper_checker (.*);

// File: bench/event_ring_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_ring_checker
// watches both channels of the length-prefixed event ring, keeps its own
// copy of the ring and its counters, works out the response to every
// accepted request and compares each response field by field
// ----------------------------------------------------------------------------
module event_ring_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  lper_pkg::lper_req_t req,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  lper_pkg::lper_rsp_t rsp,
	input  logic                at_end,
	output int unsigned         fail_count
);
	import lper_pkg::*;

	localparam int unsigned DEPTH = BUF_WORDS_DEF;

	logic [WORD_W-1:0] ring_copy [DEPTH];
	logic [31:0]       wr_words;
	logic [31:0]       rd_words;
	logic [31:0]       wr_events;
	logic [31:0]       rd_events;
	logic [LEN_W-1:0]  wr_left;
	logic [LEN_W-1:0]  wr_off;
	logic [LEN_W-1:0]  rd_left;
	logic [LEN_W-1:0]  rd_off;
	lper_rsp_t         due_rsp [$];
	lper_rsp_t         want;
	bit                reported;

	function automatic int unsigned slot(logic [31:0] base, logic [31:0] off);
		return ((base % DEPTH) + off) % DEPTH;
	endfunction

	function automatic void wipe_ring();
		foreach (ring_copy[i])
			ring_copy[i] = '0;
		wr_words  = '0;
		rd_words  = '0;
		wr_events = '0;
		rd_events = '0;
		wr_left   = '0;
		wr_off    = '0;
		rd_left   = '0;
		rd_off    = '0;
	endfunction

	function automatic lper_rsp_t advance_ring(lper_req_t r);
		lper_rsp_t   res;
		logic [31:0] len;
		logic [31:0] used;
		res = '0;
		case (r.command)
			CMD_PUSH: begin
				res.event_count = wr_events;
				if (wr_left == '0) begin
					len  = 32'(r.event_words);
					used = wr_words - rd_words;
					if (len == 0 || len + 1 >= DEPTH) begin
						res.status = ST_BAD_LEN;
						return res;
					end
					if (!(r.serial == 0 || r.serial - 1 == wr_events) ||
							!(used < DEPTH - (len + 1))) begin
						res.status = ST_REFUSED;
						return res;
					end
					ring_copy[slot(wr_words, 0)] = len;
					ring_copy[slot(wr_words, 1)] = r.data_word;
					wr_off  = LEN_W'(1);
					wr_left = LEN_W'(len - 32'd1);
				end else begin
					ring_copy[slot(wr_words, 32'(wr_off) + 32'd1)] = r.data_word;
					wr_off  = wr_off + LEN_W'(1);
					wr_left = wr_left - LEN_W'(1);
				end
				res.status = ST_OK;
				if (wr_left == '0) begin
					wr_words      = wr_words + 32'(wr_off) + 32'd1;
					wr_events     = wr_events + 32'd1;
					wr_off        = '0;
					res.last_word = 1'b1;
				end
				res.event_count = wr_events;
			end
			CMD_POP: begin
				res.event_count = rd_events;
				if (rd_left == '0) begin
					if (wr_words == rd_words) begin
						res.status = ST_EMPTY;
						return res;
					end
					len = 32'(ring_copy[slot(rd_words, 0)][LEN_W-1:0]);
					if (len == 0)
						len = 32'd1;
					res.out_word = ring_copy[slot(rd_words, 1)];
					rd_off  = LEN_W'(1);
					rd_left = LEN_W'(len - 32'd1);
				end else begin
					res.out_word = ring_copy[slot(rd_words, 32'(rd_off) + 32'd1)];
					rd_off  = rd_off + LEN_W'(1);
					rd_left = rd_left - LEN_W'(1);
				end
				res.status = ST_OK;
				if (rd_left == '0) begin
					rd_words      = rd_words + 32'(rd_off) + 32'd1;
					rd_events     = rd_events + 32'd1;
					rd_off        = '0;
					res.last_word = 1'b1;
				end
				res.event_count = rd_events;
			end
			CMD_CLEAR: wipe_ring();
			default: ;
		endcase
		return res;
	endfunction

	function automatic void field_check(string what, logic [31:0] exp, logic [31:0] act);
		if (exp !== act) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp, act);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_ring();
			due_rsp.delete();
			fail_count = 0;
			reported   = 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (due_rsp.size() == 0) begin
					fail_count++;
					$display("%0t: response with none expected, expected nothing, actual %p",
						$time, rsp);
				end else begin
					want = due_rsp.pop_front();
					field_check("status", 32'(want.status), 32'(rsp.status));
					field_check("out_word", want.out_word, rsp.out_word);
					field_check("last_word", 32'(want.last_word), 32'(rsp.last_word));
					field_check("event_count", want.event_count, rsp.event_count);
				end
			end
			if (req_valid && !req_stall)
				due_rsp.push_back(advance_ring(req));
			if (at_end && !reported) begin
				reported = 1'b1;
				if (due_rsp.size() != 0) begin
					fail_count += due_rsp.size();
					$display("%0t: responses missing, expected %0d more, actual 0",
						$time, due_rsp.size());
				end
			end
		end
	end

endmodule

// File: bench/tb_length_prefixed_event_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_event_ring
// drives push, pop, clear and no-op requests into the event ring: a short
// directed run over the corner cases, then random well-formed events with
// interleaved pops and some noise; the checker beside the block predicts
// and compares every response
// ----------------------------------------------------------------------------
module tb_length_prefixed_event_ring;
	import lper_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	lper_req_t   req;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	lper_rsp_t   rsp;
	logic        at_end;
	int unsigned fail_count;

	int unsigned  n_sent;
	int unsigned  n_rsp;
	int unsigned  n_items;
	lper_status_t last_status;
	bit           quiet;
	logic [31:0]  ev_done;

	always #2 clk = ~clk;

	length_prefixed_event_ring i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	event_ring_checker i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.at_end     (at_end),
		.fail_count (fail_count)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_rsp       <= 0;
			last_status <= ST_OK;
		end else if (rsp_valid && !rsp_stall) begin
			n_rsp       <= n_rsp + 1;
			last_status <= rsp.status;
		end
	end

	always @(negedge clk)
		rsp_stall <= !quiet && ($urandom_range(0, 99) < 22);

	function automatic lper_req_t req_of(lper_cmd_t c, logic [31:0] d, logic [11:0] n,
			logic [31:0] s);
		lper_req_t r;
		r.command     = c;
		r.data_word   = d;
		r.event_words = n;
		r.serial      = s;
		return r;
	endfunction

	task automatic send_req(lper_req_t item);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 22) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req       = item;
		do
			@(posedge clk);
		while (req_stall);
		n_sent++;
	endtask

	// hold the request side idle until every response is back
	task automatic settle();
		@(negedge clk);
		req_valid = 1'b0;
		while (n_rsp != n_sent)
			@(negedge clk);
	endtask

	task automatic close_event();
		ev_done++;
	endtask

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int unsigned open_left;
		int unsigned cur_len;
		int unsigned pop_burst;
		int unsigned pick;
		int unsigned sel;
		logic [31:0] cur_ser;
		bit          pending;
		bit          wrong;

		arst_n            = 1'b0;
		req_valid         = 1'b0;
		req               = '0;
		at_end            = 1'b0;
		quiet             = 1'b0;
		n_sent            = 0;
		n_items           = 0;
		ev_done           = '0;
		open_left         = 0;
		cur_len           = 0;
		pop_burst         = 0;
		pending           = 1'b0;
		wrong             = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corner cases
		send_req(req_of(CMD_POP, 32'h1234_5678, 12'd1, 32'd0));
		send_req(req_of(CMD_PUSH, 32'h0000_0001, 12'd0, 32'd0));
		send_req(req_of(CMD_PUSH, 32'h0000_0002, 12'hFFF, 32'd0));
		send_req(req_of(CMD_NOP, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF));
		send_req(req_of(CMD_PUSH, 32'hFFFF_FFFF, 12'd1, 32'd1));
		send_req(req_of(CMD_PUSH, 32'h0000_0000, 12'd3, 32'hFFFF_FFFF));
		send_req(req_of(CMD_PUSH, 32'h0000_0000, 12'd3, 32'd2));
		send_req(req_of(CMD_PUSH, 32'hA5A5_A5A5, 12'hABC, 32'd7));
		send_req(req_of(CMD_POP, 32'd0, 12'd0, 32'd0));
		send_req(req_of(CMD_PUSH, 32'h5A5A_5A5A, 12'd3, 32'd0));
		send_req(req_of(CMD_PUSH, 32'h0F0F_0F0F, 12'd4094, 32'd0));
		repeat (4)
			send_req(req_of(CMD_POP, 32'd0, 12'd0, 32'd0));
		send_req(req_of(CMD_PUSH, 32'h0000_0011, 12'd2, 32'd0));
		send_req(req_of(CMD_CLEAR, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF));
		send_req(req_of(CMD_POP, 32'd0, 12'd0, 32'd0));
		send_req(req_of(CMD_PUSH, 32'h8000_0000, 12'd2, 32'd1));
		send_req(req_of(CMD_PUSH, 32'h7FFF_FFFF, 12'd2, 32'd1));
		send_req(req_of(CMD_POP, 32'd0, 12'd0, 32'd0));
		send_req(req_of(CMD_CLEAR, 32'd0, 12'd0, 32'd0));
		send_req(req_of(CMD_POP, 32'd0, 12'd0, 32'd0));
		settle();

		// random events with interleaved pops and noise
		while (n_items < 1450) begin
			quiet = (n_items >= 500 && n_items < 800);
			pick  = $urandom_range(0, 99);
			if (pick < 3) begin
				sel = $urandom_range(0, 9);
				if (sel < 5) begin
					send_req(req_of(CMD_NOP, $urandom, 12'($urandom), $urandom));
				end else if (sel < 9 && open_left == 0) begin
					send_req(req_of(CMD_PUSH, $urandom,
						$urandom_range(0, 1) ? 12'd0 : 12'hFFF, $urandom));
					n_items++;
				end else if (n_items < 400) begin
					send_req(req_of(CMD_CLEAR, $urandom, 12'($urandom), $urandom));
					n_items++;
					open_left         = 0;
					ev_done           = '0;
				end
			end else if (pop_burst > 0 || pick < 45) begin
				send_req(req_of(CMD_POP, $urandom, 12'($urandom), $urandom));
				n_items++;
				if (pop_burst > 0)
					pop_burst--;
			end else if (open_left > 0) begin
				send_req(req_of(CMD_PUSH, $urandom,
					($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'(cur_len),
					($urandom_range(0, 9) == 0) ? $urandom : cur_ser));
				n_items++;
				open_left--;
				if (open_left == 0)
					close_event();
			end else begin
				if (!pending) begin
					sel = $urandom_range(0, 99);
					if (sel < 78)
						cur_len = $urandom_range(1, 8);
					else if (sel < 95)
						cur_len = $urandom_range(9, 100);
					else
						cur_len = $urandom_range(101, 800);
					wrong = ($urandom_range(0, 9) == 0);
				end
				if (wrong && !pending) begin
					cur_ser = $urandom;
					if (cur_ser == 0 || cur_ser == ev_done + 1)
						cur_ser = ev_done + 3;
				end else begin
					cur_ser = $urandom_range(0, 1) ? 32'd0 : ev_done + 1;
				end
				send_req(req_of(CMD_PUSH, $urandom, 12'(cur_len), cur_ser));
				n_items++;
				settle();
				if (last_status == ST_OK) begin
					pending   = 1'b0;
					open_left = cur_len - 1;
					if (open_left == 0)
						close_event();
				end else begin
					// producer retries after draining some words
					pending   = 1'b1;
					pop_burst = $urandom_range(4, 24);
				end
			end
		end

		quiet = 1'b0;
		settle();
		repeat (10) @(negedge clk);
		at_end = 1'b1;
		repeat (2) @(negedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
